// File: hdl/atds_pkg.sv
// shared types and constants of the grade averaging and ranking block
package atds_pkg;

  localparam int GRADE_W = 10;
  localparam int AVG_W   = 10;
  localparam int IDX_W   = 6;
  localparam int SUM_W   = 18;
  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  typedef struct packed {
    logic [AVG_W-1:0] avg;
    logic [IDX_W-1:0] idx;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV_RUN,
    S_STORE,
    S_SORT_RD_I,
    S_SORT_LD_I,
    S_SORT_RD_J,
    S_SORT_CMP_J,
    S_SORT_WB_I,
    S_OUT_RD,
    S_OUT_LOAD,
    S_OUT_HOLD
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic store;
    logic rd_i;
    logic ld_i;
    logic rd_j;
    logic cmp_j;
    logic j_next;
    logic wb_i;
    logic i_next;
    logic rd_k;
    logic ld_out;
    logic k_next;
    logic clear_total;
  } cmd_t;

  typedef struct packed {
    logic closing;
    logic div_done;
    logic eoc_pend;
    logic j_eq_i;
    logic j_last;
    logic i_last;
    logic k_last;
  } sts_t;

endpackage

// File: hdl/atds_ctrl.sv
// sequencer for accumulation, division, exchange sort and result output
module atds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_stall_i,
  input  atds_pkg::sts_t sts_i,
  output atds_pkg::cmd_t cmd_o,
  output logic           in_stall_o,
  output logic           out_valid_o
);
  import atds_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.closing) state_d = S_DIV_INIT;
      end
      S_DIV_INIT: state_d = S_DIV_RUN;
      S_DIV_RUN: begin
        if (sts_i.div_done) state_d = S_STORE;
      end
      S_STORE: state_d = sts_i.eoc_pend ? S_SORT_RD_I : S_IDLE;
      S_SORT_RD_I: state_d = S_SORT_LD_I;
      S_SORT_LD_I: state_d = S_SORT_RD_J;
      S_SORT_RD_J: begin
        if (!sts_i.j_eq_i) begin
          state_d = S_SORT_CMP_J;
        end else if (sts_i.j_last) begin
          state_d = S_SORT_WB_I;
        end
      end
      S_SORT_CMP_J: state_d = sts_i.j_last ? S_SORT_WB_I : S_SORT_RD_J;
      S_SORT_WB_I: state_d = sts_i.i_last ? S_OUT_RD : S_SORT_RD_I;
      S_OUT_RD: state_d = S_OUT_LOAD;
      S_OUT_LOAD: state_d = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (!out_stall_i) state_d = sts_i.k_last ? S_IDLE : S_OUT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.accept  = in_valid_i;
      end
      S_DIV_INIT: cmd_o.div_init = 1'b1;
      S_DIV_RUN: cmd_o.div_step = 1'b1;
      S_STORE: cmd_o.store = 1'b1;
      S_SORT_RD_I: cmd_o.rd_i = 1'b1;
      S_SORT_LD_I: cmd_o.ld_i = 1'b1;
      S_SORT_RD_J: begin
        if (!sts_i.j_eq_i) begin
          cmd_o.rd_j = 1'b1;
        end else if (!sts_i.j_last) begin
          cmd_o.j_next = 1'b1;
        end
      end
      S_SORT_CMP_J: begin
        cmd_o.cmp_j  = 1'b1;
        cmd_o.j_next = !sts_i.j_last;
      end
      S_SORT_WB_I: begin
        cmd_o.wb_i   = 1'b1;
        cmd_o.i_next = !sts_i.i_last;
      end
      S_OUT_RD: cmd_o.rd_k = 1'b1;
      S_OUT_LOAD: cmd_o.ld_out = 1'b1;
      S_OUT_HOLD: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.k_next      = !sts_i.k_last;
          cmd_o.clear_total = sts_i.k_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hdl/atds_dp.sv
// accumulator, restoring divider, record memory and sort/output counters
module atds_dp #(
  parameter int MAX_STUDENTS = 64,
  parameter int MAX_GRADES   = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [atds_pkg::GRADE_W-1:0]  grade_i,
  input  logic                          end_of_student_i,
  input  logic                          end_of_class_i,
  input  atds_pkg::cmd_t                cmd_i,
  output atds_pkg::sts_t                sts_o,
  output logic [atds_pkg::IDX_W-1:0]    student_index_o,
  output logic [atds_pkg::AVG_W-1:0]    average_o,
  output logic                          last_result_o
);
  import atds_pkg::*;

  localparam int CW  = $clog2(MAX_GRADES + 1);
  localparam int TW  = $clog2(MAX_STUDENTS + 1);
  localparam int IW  = $clog2(MAX_STUDENTS);
  localparam int DCW = $clog2(SUM_W);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CW-1:0]    count_q, count_d;
  logic [TW-1:0]    total_q, total_d;
  logic             eoc_pend_q;

  // accumulation
  logic [SUM_W:0] sum_ext;
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(grade_i);

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.accept && (count_q < CW'(MAX_GRADES))) begin
      sum_d   = (sum_ext > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_ext[SUM_W-1:0];
      count_d = count_q + CW'(1);
    end
    if (cmd_i.store) begin
      sum_d   = '0;
      count_d = '0;
      if (total_q != TW'(MAX_STUDENTS)) total_d = total_q + TW'(1);
    end
    if (cmd_i.clear_total) total_d = '0;
  end

  // restoring divider, one quotient bit per cycle
  logic [SUM_W-1:0] quo_q;
  logic [CW-1:0]    rem_q;
  logic [DCW-1:0]   div_cnt_q;
  logic [CW:0]      trial;
  logic             fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? CW'(trial - {1'b0, count_q}) : CW'(trial);
    end
  end

  logic [AVG_W-1:0] avg_val;
  assign avg_val = (count_q == '0) ? '0 : quo_q[AVG_W-1:0];

  // loop counters
  logic [IW-1:0] i_q, j_q, k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      total_q    <= '0;
      eoc_pend_q <= 1'b0;
      div_cnt_q  <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      total_q <= total_d;
      if (cmd_i.accept) eoc_pend_q <= end_of_class_i;
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DCW'(1);
      end
      if (cmd_i.store) begin
        i_q <= '0;
        k_q <= '0;
      end else if (cmd_i.i_next) begin
        i_q <= i_q + IW'(1);
      end else if (cmd_i.k_next) begin
        k_q <= k_q + IW'(1);
      end
      if (cmd_i.ld_i) begin
        j_q <= '0;
      end else if (cmd_i.j_next) begin
        j_q <= j_q + IW'(1);
      end
    end
  end

  // record memory, one write and one registered read port
  rec_t          mem [MAX_STUDENTS];
  rec_t          rdata_q;
  rec_t          held_q;
  rec_t          wdata;
  logic [IW-1:0] waddr, raddr;
  logic          we, re, swap;
  logic          full;

  assign full = total_q == TW'(MAX_STUDENTS);
  assign swap = held_q.avg > rdata_q.avg;

  always_comb begin
    we    = 1'b0;
    waddr = i_q;
    wdata = held_q;
    if (cmd_i.store) begin
      we        = !full;
      waddr     = total_q[IW-1:0];
      wdata.avg = avg_val;
      wdata.idx = IDX_W'(total_q);
    end else if (cmd_i.cmp_j) begin
      we    = swap;
      waddr = j_q;
    end else if (cmd_i.wb_i) begin
      we = 1'b1;
    end
  end

  assign re    = cmd_i.rd_i | cmd_i.rd_j | cmd_i.rd_k;
  assign raddr = cmd_i.rd_j ? j_q : (cmd_i.rd_k ? k_q : i_q);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_i) begin
      held_q <= rdata_q;
    end else if (cmd_i.cmp_j && swap) begin
      held_q <= rdata_q;
    end
  end

  // result register
  logic [IDX_W-1:0] out_idx_q;
  logic [AVG_W-1:0] out_avg_q;
  logic             out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_idx_q  <= rdata_q.idx;
      out_avg_q  <= rdata_q.avg;
      out_last_q <= sts_o.k_last;
    end
  end

  assign student_index_o = out_idx_q;
  assign average_o       = out_avg_q;
  assign last_result_o   = out_last_q;

  always_comb begin
    sts_o          = '0;
    sts_o.closing  = end_of_student_i | end_of_class_i;
    sts_o.div_done = div_cnt_q == DCW'(SUM_W - 1);
    sts_o.eoc_pend = eoc_pend_q;
    sts_o.j_eq_i   = j_q == i_q;
    sts_o.j_last   = (TW'(j_q) + TW'(1)) == total_q;
    sts_o.i_last   = (TW'(i_q) + TW'(1)) == total_q;
    sts_o.k_last   = (TW'(k_q) + TW'(1)) == total_q;
  end

endmodule

// File: hdl/average_then_descending_sort_top.sv
// top level of the grade averaging and descending ranking block
//
// input channel: one grade per transfer, with end_of_student marking a
// student's last grade and end_of_class marking the class's last grade
// (it also closes the open student). output channel: one record per stored
// student, highest average first, last_result set on the final transfer.
// a grade that closes nothing is accepted straight from idle. a closing
// grade passes through the transfer, divider load, the steps of the
// bit-serial restoring divider, and the store into the record memory;
// the divider takes the largest share. after a class end the exchange
// sort runs over n records, its time set by the single read port of the
// record memory (each record is fetched, then compared in its own state).
// output then steps through read, load and hold states for each record.
// in_stall_o is high throughout division, sort and output.
// while out_stall_i is high the current record and its valid stay put.
// reset clears the accumulators and the student count; the record memory
// is not cleared, as only written entries are ever read.
module average_then_descending_sort_top #(
  parameter int MAX_STUDENTS = 64,
  parameter int MAX_GRADES   = 255
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [atds_pkg::GRADE_W-1:0] grade_i,
  input  logic                         end_of_student_i,
  input  logic                         end_of_class_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [atds_pkg::IDX_W-1:0]   student_index_o,
  output logic [atds_pkg::AVG_W-1:0]   average_o,
  output logic                         last_result_o
);
  import atds_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  atds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  atds_dp #(
    .MAX_STUDENTS (MAX_STUDENTS),
    .MAX_GRADES   (MAX_GRADES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grade_i          (grade_i),
    .end_of_student_i (end_of_student_i),
    .end_of_class_i   (end_of_class_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .student_index_o  (student_index_o),
    .average_o        (average_o),
    .last_result_o    (last_result_o)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the grade averaging and descending ranking block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import atds_pkg::*;

  // must match the block's default parameters
  localparam int NUM_STUDENTS = 64;
  localparam int GRADE_LIMIT  = 255;
  // long receiver hold-off, well beyond one class of eight students
  localparam int HOLD_CYCLES  = 1500;

  // one ranked record as it should leave the block
  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [AVG_W-1:0] avg;
    logic             last;
  } ranked_t;

  // predicts the ranked records of each class and checks them in order
  class rank_predictor;
    logic [SUM_W-1:0] grade_sum;
    logic [7:0]       grade_count;
    logic [6:0]       student_total;
    logic [AVG_W-1:0] avg_tab [NUM_STUDENTS];
    logic [IDX_W-1:0] idx_tab [NUM_STUDENTS];
    ranked_t          ranked_due [$];
    int unsigned      mismatches;

    function new();
      grade_sum     = '0;
      grade_count   = '0;
      student_total = '0;
      mismatches    = 0;
    endfunction

    // one accepted grade transfer
    function void take_grade(logic [GRADE_W-1:0] g, logic eos, logic eoc);
      logic [SUM_W:0]   wide_sum;
      logic [SUM_W-1:0] quot;
      logic [AVG_W-1:0] tmp_avg;
      logic [IDX_W-1:0] tmp_idx;
      ranked_t          rec;
      // grades past the per-student limit are dropped
      if (grade_count < GRADE_LIMIT) begin
        wide_sum    = {1'b0, grade_sum} + g;
        grade_sum   = (wide_sum > SUM_LIMIT) ? SUM_LIMIT : wide_sum[SUM_W-1:0];
        grade_count = grade_count + 1'b1;
      end
      // class end closes the open student as well
      if (eos || eoc) begin
        quot = (grade_count != 0) ? grade_sum / grade_count : '0;
        if (student_total < NUM_STUDENTS) begin
          avg_tab[student_total] = quot[AVG_W-1:0];
          idx_tab[student_total] = student_total[IDX_W-1:0];
          student_total          = student_total + 1'b1;
        end
        grade_sum   = '0;
        grade_count = '0;
      end
      if (!eoc) return;
      // all-pairs exchange: swap i and j whenever key i exceeds key j
      for (int i = 0; i < student_total; i++) begin
        for (int j = 0; j < student_total; j++) begin
          if (avg_tab[i] > avg_tab[j]) begin
            tmp_avg    = avg_tab[i];
            tmp_idx    = idx_tab[i];
            avg_tab[i] = avg_tab[j];
            idx_tab[i] = idx_tab[j];
            avg_tab[j] = tmp_avg;
            idx_tab[j] = tmp_idx;
          end
        end
      end
      for (int k = 0; k < student_total; k++) begin
        rec.idx  = idx_tab[k];
        rec.avg  = avg_tab[k];
        rec.last = (k + 1 == student_total);
        ranked_due.push_back(rec);
      end
      student_total = '0;
    endfunction

    // one accepted result transfer against the oldest expectation
    function void check_rank(logic [IDX_W-1:0] idx, logic [AVG_W-1:0] avg, logic last);
      ranked_t want;
      if (ranked_due.size() == 0) begin
        $error("result with none expected: student_index %0d average %0d last_result %0b",
               idx, avg, last);
        mismatches++;
        return;
      end
      want = ranked_due.pop_front();
      if (idx !== want.idx) begin
        $error("student_index: expected %0d, actual %0d", want.idx, idx);
        mismatches++;
      end
      if (avg !== want.avg) begin
        $error("average: expected %0d, actual %0d", want.avg, avg);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_result: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [GRADE_W-1:0] grade_i;
  logic               end_of_student_i;
  logic               end_of_class_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IDX_W-1:0]   student_index_o;
  logic [AVG_W-1:0]   average_o;
  logic               last_result_o;

  rank_predictor board = new();

  // idling odds in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // asks the receiver for one long hold-off
  logic hold_req = 1'b0;
  int grades_sent = 0;

  average_then_descending_sort_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .grade_i          (grade_i),
    .end_of_student_i (end_of_student_i),
    .end_of_class_i   (end_of_class_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .student_index_o  (student_index_o),
    .average_o        (average_o),
    .last_result_o    (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  // offers one grade, idling at random first; returns at the accepting edge
  // with valid still high so that the next transfer can follow back to back
  task automatic send_grade(input logic [GRADE_W-1:0] g, input logic eos, input logic eoc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    grade_i          <= g;
    end_of_student_i <= eos;
    end_of_class_i   <= eoc;
    do @(posedge clk_i); while (in_stall_o);
    board.take_grade(g, eos, eoc);
    grades_sent++;
  endtask

  // a well-formed class with random content; the closing grade carries
  // end_of_student only half the time
  task automatic send_class(input int n_students, input int most_grades);
    int                 n_grades;
    int                 mode;
    logic [GRADE_W-1:0] g;
    mode = $urandom_range(0, 2);
    for (int s = 0; s < n_students; s++) begin
      n_grades = $urandom_range(1, most_grades);
      for (int k = 0; k < n_grades; k++) begin
        case (mode)
          0:       g = GRADE_W'($urandom_range(0, 1023));
          1:       g = GRADE_W'($urandom_range(0, 1000));
          default: g = GRADE_W'(250 * $urandom_range(0, 4));  // coarse values give many ties
        endcase
        if (s == n_students - 1 && k == n_grades - 1)
          send_grade(g, 1'($urandom_range(0, 1)), 1'b1);
        else
          send_grade(g, k == n_grades - 1, 1'b0);
      end
    end
  endtask

  // sender stays quiet until every expected record has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.ranked_due.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each transfer, then pick the stall for the next cycle
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_rank(student_index_o, average_o, last_result_o);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int target;
    in_valid_i       <= 1'b0;
    grade_i          <= '0;
    end_of_student_i <= 1'b0;
    end_of_class_i   <= 1'b0;
    rst_ni           <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, full marks, above-range grade, truncating average,
    // a tie, and a class end that closes a student without its own mark
    send_grade(10'd0,    1'b1, 1'b0);
    send_grade(10'd1000, 1'b0, 1'b0);
    send_grade(10'd1000, 1'b1, 1'b0);
    send_grade(10'd1023, 1'b1, 1'b0);
    send_grade(10'd1,    1'b0, 1'b0);
    send_grade(10'd2,    1'b1, 1'b0);
    send_grade(10'd500,  1'b1, 1'b0);
    send_grade(10'd500,  1'b1, 1'b0);
    send_grade(10'd7,    1'b0, 1'b1);
    // single-grade class with both marks
    send_grade(10'd1023, 1'b1, 1'b1);
    // all records tied at zero
    send_grade(10'd0, 1'b1, 1'b0);
    send_grade(10'd0, 1'b1, 1'b0);
    send_grade(10'd0, 1'b1, 1'b1);
    // class end arriving mid-student
    send_grade(10'd10, 1'b1, 1'b0);
    send_grade(10'd3,  1'b0, 1'b0);
    send_grade(10'd4,  1'b0, 1'b1);
    drain_results();

    // more students than the record memory holds: the extra ones are dropped
    for (int s = 0; s < NUM_STUDENTS + 2; s++)
      send_grade(GRADE_W'($urandom_range(0, 1023)), 1'b1, s == NUM_STUDENTS + 1);
    drain_results();

    // random classes under four idling mixes, draining between phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      target = grades_sent + 35;
      if (phase == 0) begin
        // long hold-off on the result side while two classes are offered
        // back to back, so the block backs up and stalls its input
        @(negedge clk_i);
        hold_req = 1'b1;
        @(posedge clk_i);
        send_class(8, 3);
        send_class(5, 2);
      end
      while (grades_sent < target) begin
        if ($urandom_range(0, 9) == 0)
          send_class($urandom_range(7, 20), 4);
        else
          send_class($urandom_range(1, 6), 4);
      end
      drain_results();
    end

    // let any stray transfer show up before the verdict
    repeat (60) @(posedge clk_i);
    if (board.mismatches == 0 && board.ranked_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // several times the slowest correct run, a sorted full class included
  initial begin : watchdog
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
hdl/atds_pkg.sv
hdl/atds_ctrl.sv
hdl/atds_dp.sv
hdl/average_then_descending_sort_top.sv
tb/tb_top.sv
